FILE: rtl/rbta_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbta_pkg
// shared types and codes for the rle / back-reference token analyzer
// ----------------------------------------------------------------------------
package rbta_pkg;

	// token kinds as reported in a record
	typedef enum logic [2:0] {
		KIND_INLINE = 3'd0,
		KIND_RLE8   = 3'd1,
		KIND_RLE16  = 3'd2,
		KIND_RLE24  = 3'd3,
		KIND_RLE32  = 3'd4,
		KIND_SHORT  = 3'd5,
		KIND_LONG   = 3'd6,
		KIND_END    = 3'd7
	} kind_t;

	// parser phase
	typedef enum logic [1:0] {
		PH_CTRL = 2'd0,
		PH_OPER = 2'd1,
		PH_SKIP = 2'd2
	} phase_t;

	// format_mode values
	localparam logic MODE_NEW = 1'b0;
	localparam logic MODE_OLD = 1'b1;

	// control byte prefixes, current format (bits 7:5)
	localparam logic [2:0] NEW_INLINE_A = 3'b000;
	localparam logic [2:0] NEW_INLINE_B = 3'b001;
	localparam logic [2:0] NEW_RLE8     = 3'b010;
	localparam logic [2:0] NEW_RLE32    = 3'b011;
	localparam logic [2:0] NEW_RLE16    = 3'b100;
	localparam logic [2:0] NEW_RLE24    = 3'b101;
	localparam logic [2:0] NEW_REF_A    = 3'b110;
	localparam logic [2:0] NEW_REF_B    = 3'b111;

	// control byte prefixes, old format (bits 7:6)
	localparam logic [1:0] OLD_INLINE = 2'b00;
	localparam logic [1:0] OLD_RLE8   = 2'b01;
	localparam logic [1:0] OLD_SHORT  = 2'b10;
	localparam logic [1:0] OLD_LONG   = 2'b11;

	// decoded control byte
	typedef struct packed {
		kind_t      kind;
		logic [7:0] dec_len;
		logic [6:0] count;
	} ctrl_t;

	// one output record
	typedef struct packed {
		kind_t       kind;
		logic [15:0] offset;
		logic [7:0]  dec_len;
		logic [6:0]  enc_len;
		logic [31:0] fill;
		logic [15:0] refer;
		logic [23:0] tot_dec;
		logic [15:0] tot_enc;
		logic        status;
		logic        done;
	} rec_t;

endpackage
`default_nettype wire

FILE: rtl/rbta_ctrl_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbta_ctrl_decode
// control byte decoder: kind, decoded length and operand/payload byte count
// ----------------------------------------------------------------------------
module rbta_ctrl_decode
	import rbta_pkg::*;
(
	input  wire logic       format_mode,
	input  wire logic [7:0] ctrl_byte,
	output ctrl_t           ctrl
);

	logic [7:0] base;

	// repeat unit count for the multi-byte rle kinds
	assign base = {3'd0, ctrl_byte[4:0]} + 8'd2;

	always_comb begin
		ctrl = '0;
		if (format_mode == MODE_OLD) begin
			ctrl.dec_len = {2'd0, ctrl_byte[5:0]};
			unique case (ctrl_byte[7:6])
				OLD_INLINE: begin
					ctrl.kind  = KIND_INLINE;
					ctrl.count = {1'b0, ctrl_byte[5:0]};
				end
				OLD_RLE8: begin
					ctrl.kind  = KIND_RLE8;
					ctrl.count = 7'd1;
				end
				OLD_SHORT: begin
					ctrl.kind  = KIND_SHORT;
					ctrl.count = 7'd1;
				end
				OLD_LONG: begin
					ctrl.kind  = KIND_LONG;
					ctrl.count = 7'd2;
				end
				default: ctrl = '0;
			endcase
		end else begin
			unique case (ctrl_byte[7:5]) inside
				NEW_INLINE_A, NEW_INLINE_B: begin
					ctrl.kind    = KIND_INLINE;
					ctrl.dec_len = {2'd0, ctrl_byte[5:0]} + 8'd1;
					ctrl.count   = {1'b0, ctrl_byte[5:0]} + 7'd1;
				end
				NEW_RLE8: begin
					ctrl.kind    = KIND_RLE8;
					ctrl.dec_len = {3'd0, ctrl_byte[4:0]} + 8'd3;
					ctrl.count   = 7'd1;
				end
				NEW_RLE32: begin
					ctrl.kind    = KIND_RLE32;
					ctrl.dec_len = {base[5:0], 2'b00};
					ctrl.count   = 7'd4;
				end
				NEW_RLE16: begin
					ctrl.kind    = KIND_RLE16;
					ctrl.dec_len = {base[6:0], 1'b0};
					ctrl.count   = 7'd2;
				end
				NEW_RLE24: begin
					ctrl.kind    = KIND_RLE24;
					ctrl.dec_len = {base[6:0], 1'b0} + base;
					ctrl.count   = 7'd3;
				end
				NEW_REF_A, NEW_REF_B: begin
					// pending back-reference, may turn out to be the end marker
					ctrl.kind    = KIND_END;
					ctrl.dec_len = {2'd0, ctrl_byte[5:0]} + 8'd4;
					ctrl.count   = 7'd2;
				end
				default: ctrl = '0;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/rbta_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbta_parser
// token parser state and record formation, one byte per fire
// ----------------------------------------------------------------------------
module rbta_parser
	import rbta_pkg::*;
#(
	parameter int OFFSET_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic       format_mode,
	input  wire logic [7:0] data_byte,
	input  wire logic       stream_start,
	input  wire logic       stream_end,
	output logic            emit,
	output rec_t            rec
);

	localparam int OW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;

	phase_t                 phase_q, phase_n, e_phase;
	logic [6:0]             rem_q, rem_n, e_rem;
	kind_t                  kind_q, kind_n, e_kind, kind_out;
	logic [7:0]             dlen_q, dlen_n, e_dlen;
	logic [31:0]            shift_q, shift_n, e_shift, opnd;
	logic [OFFSET_BITS-1:0] coff_q, coff_n, e_coff;
	logic [OFFSET_BITS-1:0] pos_q, pos_n, e_pos;
	logic [23:0]            dtot_q, dtot_n, e_dtot;
	logic [15:0]            etot_q, etot_n, e_etot;
	logic                   ended_q, ended_n, e_ended;
	logic [24:0]            dsum;
	logic [6:0]             full_enc;
	logic [6:0]             enc_len;
	logic [OW-1:0]          coff_wide;
	logic                   complete;
	ctrl_t                  ctrl;

	rbta_ctrl_decode u_decode (
		.format_mode (format_mode),
		.ctrl_byte   (data_byte),
		.ctrl        (ctrl)
	);

	always_comb begin
		// stream start sees the cleared state
		e_phase = stream_start ? PH_CTRL     : phase_q;
		e_rem   = stream_start ? '0          : rem_q;
		e_kind  = stream_start ? KIND_INLINE : kind_q;
		e_dlen  = stream_start ? '0          : dlen_q;
		e_shift = stream_start ? '0          : shift_q;
		e_coff  = stream_start ? '0          : coff_q;
		e_pos   = stream_start ? '0          : pos_q;
		e_dtot  = stream_start ? '0          : dtot_q;
		e_etot  = stream_start ? '0          : etot_q;
		e_ended = stream_start ? 1'b0        : ended_q;

		phase_n  = e_phase;
		rem_n    = e_rem;
		kind_n   = e_kind;
		dlen_n   = e_dlen;
		shift_n  = e_shift;
		coff_n   = e_coff;
		pos_n    = e_pos;
		dtot_n   = e_dtot;
		etot_n   = e_etot;
		ended_n  = e_ended;
		complete = 1'b0;
		emit     = 1'b0;
		opnd     = e_shift;
		kind_out = e_kind;
		full_enc = 7'd3;
		enc_len  = '0;
		dsum     = '0;

		if (!e_ended) begin
			pos_n  = e_pos + OFFSET_BITS'(1);
			etot_n = (e_etot == 16'hffff) ? e_etot : e_etot + 16'd1;

			if (e_phase == PH_CTRL) begin
				coff_n   = e_pos;
				kind_n   = ctrl.kind;
				dlen_n   = ctrl.dec_len;
				rem_n    = ctrl.count;
				shift_n  = '0;
				complete = (ctrl.count == 7'd0);
				if (complete) begin
					phase_n = PH_CTRL;
				end else if (ctrl.kind == KIND_INLINE) begin
					phase_n = PH_SKIP;
				end else begin
					phase_n = PH_OPER;
				end
			end else begin
				if (e_phase == PH_OPER) begin
					shift_n = {e_shift[23:0], data_byte};
				end
				if (e_rem != 7'd0) begin
					rem_n = e_rem - 7'd1;
				end
				complete = (rem_n == 7'd0);
			end

			opnd = shift_n;
			emit = complete || stream_end;

			case (kind_n)
				KIND_INLINE: full_enc = dlen_n[6:0] + 7'd1;
				KIND_RLE8:   full_enc = 7'd2;
				KIND_RLE16:  full_enc = 7'd3;
				KIND_RLE24:  full_enc = 7'd4;
				KIND_RLE32:  full_enc = 7'd5;
				KIND_SHORT:  full_enc = 7'd2;
				default:     full_enc = 7'd3;
			endcase

			// bytes consumed so far, before the post-record clear
			enc_len = full_enc - rem_n;

			// a back-reference to zero is the end marker, anything else a long ref
			kind_out = kind_n;
			if (kind_n == KIND_END && (!complete || opnd[15:0] != 16'd0)) begin
				kind_out = KIND_LONG;
			end

			dsum = {1'b0, e_dtot} + {17'd0, dlen_n};
			if (emit) begin
				dtot_n  = dsum[24] ? 24'hffffff : dsum[23:0];
				ended_n = (kind_out == KIND_END);
				phase_n = PH_CTRL;
				rem_n   = '0;
				shift_n = '0;
			end
		end

		coff_wide    = OW'(coff_n);
		rec.kind     = kind_out;
		rec.offset   = coff_wide[15:0];
		rec.dec_len  = dlen_n;
		rec.enc_len  = enc_len;
		rec.fill     = (kind_out >= KIND_RLE8 && kind_out <= KIND_RLE32) ? opnd : '0;
		rec.refer    = (kind_out >= KIND_SHORT) ? opnd[15:0] : '0;
		rec.tot_dec  = dtot_n;
		rec.tot_enc  = etot_n;
		rec.status   = !complete;
		rec.done     = stream_end || (kind_out == KIND_END);
	end

	// enc_len above is taken before the post-record clear of the remaining count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CTRL;
			rem_q   <= '0;
			kind_q  <= KIND_INLINE;
			dlen_q  <= '0;
			shift_q <= '0;
			coff_q  <= '0;
			pos_q   <= '0;
			dtot_q  <= '0;
			etot_q  <= '0;
			ended_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			rem_q   <= rem_n;
			kind_q  <= kind_n;
			dlen_q  <= dlen_n;
			shift_q <= shift_n;
			coff_q  <= coff_n;
			pos_q   <= pos_n;
			dtot_q  <= dtot_n;
			etot_q  <= etot_n;
			ended_q <= ended_n;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/rle_backref_token_analyzer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rle_backref_token_analyzer_core
// byte-serial token analyzer for an rle / back-reference compressed stream
// ----------------------------------------------------------------------------
// Takes one stream byte per transfer on the byte channel and returns one
// record per finished (or truncated) token on the record channel. The block
// sustains one byte per clock: a byte register feeds a single pass of parser
// logic whose result lands in the record register, so a record is offered
// once the byte that completes its token has passed through the byte
// register and the parser. Only a held record (record stall high) slows
// intake, through byte_stall. format_mode is written over the cfg channel,
// which is always ready, and is sampled when a control byte is decoded.
// ----------------------------------------------------------------------------
module rle_backref_token_analyzer_core
	import rbta_pkg::*;
#(
	parameter int OFFSET_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,
	// byte channel
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        stream_start,
	input  wire logic        stream_end,
	// record channel
	output logic             rec_valid,
	input  wire logic        rec_stall,
	output logic [2:0]       token_kind,
	output logic [15:0]      token_offset,
	output logic [7:0]       decoded_length,
	output logic [6:0]       encoded_length,
	output logic [31:0]      fill_pattern,
	output logic [15:0]      reference,
	output logic [23:0]      total_decoded,
	output logic [15:0]      total_encoded,
	output logic             status,
	output logic             stream_done
);

	logic       format_mode_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       end_s1;
	logic       fire;
	logic       emit;
	rec_t       rec;
	rec_t       rec_q;
	logic       rec_valid_q;

	// config register, written at any time the channel offers data
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_mode_q <= MODE_NEW;
		end else if (cfg_valid && cfg_ready) begin
			format_mode_q <= cfg_data;
		end
	end

	// the byte in stage 1 is processed once the record register can take a result
	assign fire       = valid_s1 && (!rec_valid_q || !rec_stall);
	assign byte_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1  <= data_byte;
			start_s1 <= stream_start;
			end_s1   <= stream_end;
		end
	end

	rbta_parser #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.format_mode  (format_mode_q),
		.data_byte    (byte_s1),
		.stream_start (start_s1),
		.stream_end   (end_s1),
		.emit         (emit),
		.rec          (rec)
	);

	// record register: reload on a new record, drop after its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (fire) begin
			rec_valid_q <= emit;
		end else if (!rec_stall) begin
			rec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			rec_q <= rec;
		end
	end

	assign rec_valid      = rec_valid_q;
	assign token_kind     = rec_q.kind;
	assign token_offset   = rec_q.offset;
	assign decoded_length = rec_q.dec_len;
	assign encoded_length = rec_q.enc_len;
	assign fill_pattern   = rec_q.fill;
	assign reference      = rec_q.refer;
	assign total_decoded  = rec_q.tot_dec;
	assign total_encoded  = rec_q.tot_enc;
	assign status         = rec_q.status;
	assign stream_done    = rec_q.done;

endmodule
`default_nettype wire
